/* design/valp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package valp_pkg;

   // label and pair widths
   localparam int LABEL_W = 8;
   localparam int PAIR_W = 2 * LABEL_W;
   localparam int LABEL_COUNT = 1 << LABEL_W;

   // image geometry
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   // register file
   localparam int CFG_WIDTH_W = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = CFG_WIDTH_W'(1024);
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(1024);

   // register index, taken from address bit 2
   localparam logic REG_IMAGE_WIDTH = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // candidate pair handed from the window stage to the seen filter
   typedef struct packed {
      logic valid;
      logic found;
      logic [LABEL_W-1:0] lo;
      logic [LABEL_W-1:0] hi;
   } pair_type;

endpackage

`default_nettype wire

/* design/valp_line_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module valp_line_buf #(
   parameter int MAX_WIDTH = valp_pkg::DEF_MAX_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push_valid,
   input wire logic [valp_pkg::LABEL_W-1:0] push_pixel,
   input wire logic [$clog2(MAX_WIDTH)-1:0] push_col,
   input wire logic push_interior,
   output valp_pkg::pair_type pair,
   output logic busy
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = valp_pkg::LABEL_W;

   // entry: upper row label in the high byte, middle row label in the low byte
   logic [2*LW-1:0] line_mem [MAX_WIDTH];

   logic [2*LW-1:0] rd_q_ff;
   logic s1_valid_ff;
   logic [LW-1:0] s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic s1_interior_ff;
   logic fwd_hit_ff;
   logic fwd_hit_in;
   logic [2*LW-1:0] fwd_data_ff;
   logic [3*LW-1:0] window_ff;
   logic [3*LW-1:0] window_in;
   logic [LW-1:0] prev_pix_ff;

   logic [2*LW-1:0] entry;
   logic [2*LW-1:0] wr_entry;
   logic [LW-1:0] upper_lbl;
   logic [LW-1:0] mid_lbl;
   logic [LW-1:0] centre;
   logic [LW-1:0] left_lbl;
   logic [LW-1:0] above_lbl;
   logic [LW-1:0] other;
   logic found;

   // line store read at accept, written back in the cycle after
   always_ff @(posedge clock) begin
      if (push_valid) begin
         rd_q_ff <= line_mem[push_col];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_entry;
      end
   end

   // forward the write-back when the next word reads the same column
   assign fwd_hit_in = s1_valid_ff && push_valid && (push_col == s1_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         window_ff <= '0;
      end else begin
         s1_valid_ff <= push_valid;
         fwd_hit_ff <= fwd_hit_in;
         if (s1_valid_ff) begin
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         s1_pix_ff <= push_pixel;
         s1_col_ff <= push_col;
         s1_interior_ff <= push_interior;
      end
      fwd_data_ff <= wr_entry;
      if (s1_valid_ff) begin
         prev_pix_ff <= s1_pix_ff;
      end
   end

   // neighbourhood of the centre pixel
   assign entry = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign upper_lbl = entry[2*LW-1:LW];
   assign mid_lbl = entry[LW-1:0];
   assign wr_entry = {mid_lbl, s1_pix_ff};
   assign centre = window_ff[LW-1:0];
   assign left_lbl = window_ff[2*LW-1:LW];
   assign above_lbl = window_ff[3*LW-1:2*LW];
   assign window_in = {upper_lbl, centre, mid_lbl};

   // first differing neighbour: below, above, left, right
   always_comb begin
      found = 1'b1;
      other = centre;
      if (centre != prev_pix_ff) begin
         other = prev_pix_ff;
      end else if (centre != above_lbl) begin
         other = above_lbl;
      end else if (centre != left_lbl) begin
         other = left_lbl;
      end else if (centre != mid_lbl) begin
         other = mid_lbl;
      end else begin
         found = 1'b0;
      end
   end

   // order the pair
   always_comb begin
      pair.valid = s1_valid_ff;
      pair.found = s1_valid_ff && s1_interior_ff && found;
      if (centre < other) begin
         pair.lo = centre;
         pair.hi = other;
      end else begin
         pair.lo = other;
         pair.hi = centre;
      end
   end

   assign busy = s1_valid_ff;

endmodule

`default_nettype wire

/* design/valp_seen_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

module valp_seen_filter (
   input wire logic clock,
   input wire logic reset,
   input wire valp_pkg::pair_type pair,
   output logic push_valid,
   output logic [valp_pkg::PAIR_W-1:0] push_data,
   output logic busy
);

   localparam int LW = valp_pkg::LABEL_W;
   localparam int NL = valp_pkg::LABEL_COUNT;

   // one row per smaller label, one bit per larger label
   logic [NL-1:0] seen_mem [NL];

   logic [NL-1:0] row_valid_ff;
   logic [NL-1:0] seen_q_ff;
   logic row_valid_q_ff;
   logic s2_valid_ff;
   logic s2_found_ff;
   logic [LW-1:0] s2_lo_ff;
   logic [LW-1:0] s2_hi_ff;
   logic fwd_hit_ff;
   logic [NL-1:0] fwd_row_ff;

   logic [NL-1:0] cur_row;
   logic [NL-1:0] new_row;
   logic emit;

   // row read issued as the pair leaves the window stage
   always_ff @(posedge clock) begin
      seen_q_ff <= seen_mem[pair.lo];
      row_valid_q_ff <= row_valid_ff[pair.lo];
      if (emit) begin
         seen_mem[s2_lo_ff] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         s2_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         s2_valid_ff <= pair.valid;
         fwd_hit_ff <= emit && (pair.lo == s2_lo_ff);
         if (emit) begin
            row_valid_ff[s2_lo_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_found_ff <= pair.found;
      s2_lo_ff <= pair.lo;
      s2_hi_ff <= pair.hi;
      fwd_row_ff <= new_row;
   end

   // current row: forwarded write, stored row, or cleared
   always_comb begin
      if (fwd_hit_ff) begin
         cur_row = fwd_row_ff;
      end else if (row_valid_q_ff) begin
         cur_row = seen_q_ff;
      end else begin
         cur_row = '0;
      end
   end

   assign emit = s2_valid_ff && s2_found_ff && !cur_row[s2_hi_ff];
   assign new_row = cur_row | (NL'(1) << s2_hi_ff);

   assign push_valid = emit;
   assign push_data = {s2_hi_ff, s2_lo_ff};
   assign busy = s2_valid_ff;

endmodule

`default_nettype wire

/* design/valp_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module valp_out_fifo (
   input wire logic clock,
   input wire logic reset,
   input wire logic push_valid,
   input wire logic [valp_pkg::PAIR_W-1:0] push_data,
   output logic pop_valid,
   input wire logic pop_ready,
   output logic [valp_pkg::PAIR_W-1:0] pop_data,
   output logic [valp_pkg::FIFO_CNT_W-1:0] count
);

   localparam int DEPTH = valp_pkg::FIFO_DEPTH;
   localparam int PW = $clog2(DEPTH);

   logic [valp_pkg::PAIR_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [valp_pkg::FIFO_CNT_W-1:0] count_ff;
   logic pop;

   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push_valid && !pop) begin
            count_ff <= count_ff + valp_pkg::FIFO_CNT_W'(1);
         end else if (pop && !push_valid) begin
            count_ff <= count_ff - valp_pkg::FIFO_CNT_W'(1);
         end
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

`default_nettype wire

/* design/voronoi_adjacent_label_pairs.sv */
// Adjacent label pairs of a label image, four-neighbourhood.
// Input stream req_*: one 8-bit pixel label per word in raster order.
// Result stream rsp_*: one word per newly found adjacent pair, the smaller
// label in the low byte, the larger one in the high byte; each distinct pair
// appears once, the first time it is seen after reset.
// Register port csr_*: image_width at address 0, image_height at address 4;
// write them only while the block is idle.
// Throughput: one pixel per clock while req_tready is high. A pair found for a
// pixel word passes the line-store read register and the seen-filter register before it is shown on rsp_tvalid.
// The line store and the seen-pair store are each read in the cycle before
// their write-back; a column or row revisited in the next cycle is forwarded.
// A four-word result queue separates the two sides: when rsp_tready stays
// low the queue fills and req_tready drops once the queue plus the words in
// flight could overflow it; nothing is lost.
// Reset clears the counters and seen-pair marks at once (one valid bit per
// seen-pair row) and sets the registers to 1024, so no clearing pass is
// needed; a new image that must report all its pairs again needs a reset.
`timescale 1ns / 1ps
`default_nettype none

module voronoi_adjacent_label_pairs #(
   parameter int MAX_WIDTH = valp_pkg::DEF_MAX_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   // req_tdata: pixel_label [7:0]
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [7:0] req_tdata,
   // rsp_tdata: low_label [7:0], high_label [15:8]
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [15:0] rsp_tdata,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [valp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [valp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [valp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = valp_pkg::CFG_WIDTH_W;
   localparam int HW = valp_pkg::CFG_HEIGHT_W;
   localparam int RW = valp_pkg::ROW_W;
   localparam int CMPW = (CW + 1 > WW) ? CW + 1 : WW;
   localparam int FCW = valp_pkg::FIFO_CNT_W;

   logic [WW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;

   logic csr_write;
   logic accept;
   logic [CMPW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic col_wrap;
   logic row_wrap;
   logic interior;

   valp_pkg::pair_type pair;
   logic lb_busy;
   logic sf_busy;
   logic push_valid;
   logic [valp_pkg::PAIR_W-1:0] push_data;
   logic [FCW-1:0] fifo_count;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= valp_pkg::WIDTH_RESET;
         height_ff <= valp_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            valp_pkg::REG_IMAGE_WIDTH: width_ff <= csr_pwdata[WW-1:0];
            valp_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[HW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         valp_pkg::REG_IMAGE_WIDTH: csr_prdata = valp_pkg::CSR_DATA_W'(width_ff);
         valp_pkg::REG_IMAGE_HEIGHT: csr_prdata = valp_pkg::CSR_DATA_W'(height_ff);
         default: csr_prdata = '0;
      endcase
   end

   // effective geometry: zero counts as one, large values saturate
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CMPW'(1);
      end else if (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end else begin
         w_eff = CMPW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (height_ff > HW'(valp_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(valp_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // accept while the queue can hold every word in flight
   assign req_tready = (fifo_count + FCW'(lb_busy) + FCW'(sf_busy))
                       < FCW'(valp_pkg::FIFO_DEPTH);
   assign accept = req_tvalid && req_tready;

   // raster position of the arriving pixel
   assign col_wrap = (CMPW'(col_ff) + CMPW'(1)) >= w_eff;
   assign row_wrap = (HW'(row_ff) + HW'(1)) >= h_eff;
   assign interior = (row_ff >= RW'(2)) && (col_ff >= CW'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? '0 : row_ff + RW'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   valp_line_buf #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_buf (
      .clock(clock),
      .reset(reset),
      .push_valid(accept),
      .push_pixel(req_tdata),
      .push_col(col_ff),
      .push_interior(interior),
      .pair(pair),
      .busy(lb_busy)
   );

   valp_seen_filter u_seen_filter (
      .clock(clock),
      .reset(reset),
      .pair(pair),
      .push_valid(push_valid),
      .push_data(push_data),
      .busy(sf_busy)
   );

   valp_out_fifo u_out_fifo (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data(push_data),
      .pop_valid(rsp_tvalid),
      .pop_ready(rsp_tready),
      .pop_data(rsp_tdata),
      .count(fifo_count)
   );

endmodule

`default_nettype wire

/* tb/tb_voronoi_adjacent_label_pairs.sv */
`timescale 1ns / 1ps

module tb_voronoi_adjacent_label_pairs;

   localparam int MAX_W = valp_pkg::DEF_MAX_WIDTH;
   localparam int LW = valp_pkg::LABEL_W;
   localparam int AW = valp_pkg::CSR_ADDR_W;
   localparam int DW = valp_pkg::CSR_DATA_W;
   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 300;
   localparam int POOL_SIZE = 8;
   localparam int PHASE_ITEMS = 150;
   localparam int TIMEOUT_NS = 4_000_000;

   typedef struct packed {
      logic [LW-1:0] hi;
      logic [LW-1:0] lo;
   } label_pair_type;

   // shadow of the block: line stores, window, counters, seen marks, pairs due
   class adjacency_board;
      logic [valp_pkg::CFG_WIDTH_W-1:0] width_reg;
      logic [valp_pkg::CFG_HEIGHT_W-1:0] height_reg;
      logic [LW-1:0] upper_line[MAX_W];
      logic [LW-1:0] middle_line[MAX_W];
      logic [3*LW-1:0] window;
      int unsigned col_now;
      int unsigned row_now;
      bit seen[valp_pkg::LABEL_COUNT*valp_pkg::LABEL_COUNT];
      label_pair_type pairs_due[$];

      function new();
         width_reg = valp_pkg::WIDTH_RESET;
         height_reg = valp_pkg::HEIGHT_RESET;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         window = '0;
         col_now = 0;
         row_now = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_W) return MAX_W;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > valp_pkg::MAX_HEIGHT) return valp_pkg::MAX_HEIGHT;
         return height_reg;
      endfunction

      function void set_reg(logic [AW-1:0] addr, logic [DW-1:0] value);
         if (addr[2] == valp_pkg::REG_IMAGE_WIDTH)
            width_reg = value[valp_pkg::CFG_WIDTH_W-1:0];
         else
            height_reg = value[valp_pkg::CFG_HEIGHT_W-1:0];
      endfunction

      // one accepted pixel word: test the centre one row up, one column left
      function void take_pixel(logic [LW-1:0] pix);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned r;
         logic [LW-1:0] up;
         logic [LW-1:0] mid;
         logic [LW-1:0] below;
         logic [LW-1:0] centre;
         logic [LW-1:0] left;
         logic [LW-1:0] above;
         logic [LW-1:0] other;
         bit found;
         label_pair_type pair;
         w = eff_width();
         h = eff_height();
         c = col_now;
         r = row_now;
         up = upper_line[c];
         mid = middle_line[c];
         below = '0;
         if (c >= 1) below = middle_line[c-1];
         if (r >= 2 && c >= 2) begin
            centre = window[7:0];
            left = window[15:8];
            above = window[23:16];
            found = 1'b1;
            other = centre;
            // fixed order: below, above, left, right
            if (centre != below) other = below;
            else if (centre != above) other = above;
            else if (centre != left) other = left;
            else if (centre != mid) other = mid;
            else found = 1'b0;
            if (found) begin
               pair.lo = (centre < other) ? centre : other;
               pair.hi = (centre < other) ? other : centre;
               if (!seen[{pair.lo, pair.hi}]) begin
                  seen[{pair.lo, pair.hi}] = 1'b1;
                  pairs_due.push_back(pair);
               end
            end
         end
         upper_line[c] = mid;
         middle_line[c] = pix;
         window = {up, window[7:0], mid};
         if (c + 1 >= w) begin
            col_now = 0;
            row_now = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_now = c + 1;
         end
      endfunction

      // compare a result word with the oldest pair due
      function bit match_pair(logic [2*LW-1:0] word, output string why);
         label_pair_type want;
         why = "";
         if (pairs_due.size() == 0) begin
            why = $sformatf("pair low %0d high %0d with none due",
                            word[7:0], word[15:8]);
            return 1'b0;
         end
         want = pairs_due.pop_front();
         if (word[7:0] !== want.lo)
            why = $sformatf("low_label %0d, expected %0d", word[7:0], want.lo);
         if (word[15:8] !== want.hi)
            why = {why, $sformatf(" high_label %0d, expected %0d", word[15:8], want.hi)};
         return why == "";
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [15:0] rsp_tdata;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [AW-1:0] csr_paddr;
   logic [DW-1:0] csr_pwdata;
   logic [DW-1:0] csr_prdata;
   logic csr_pready;

   adjacency_board board;
   int fail_count;
   int send_idle_pct;
   int stall_pct;
   bit hold_go;
   bit hold_taken;
   int hold_left;
   logic [7:0] gen_line[MAX_W];
   int unsigned gen_col;
   int unsigned gen_w;
   logic [7:0] label_pool[POOL_SIZE];

   // corner image 3 x 8: above, left, right and below cases, a repeated pair,
   // labels 0 and 255
   logic [7:0] corner_labels[24] = '{
      8'd0, 8'd255, 8'd0,
      8'd0, 8'd0,   8'd0,
      8'd1, 8'd0,   8'd0,
      8'd0, 8'd0,   8'd254,
      8'd7, 8'd0,   8'd0,
      8'd0, 8'd128, 8'd0,
      8'd0, 8'd0,   8'd0,
      8'd0, 8'd0,   8'd0
   };

   voronoi_adjacent_label_pairs DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // accepted words on both channels
   always @(posedge clock) begin : watch_words
      string why;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            if (!board.match_pair(rsp_tdata, why)) report_mismatch(why);
         if (req_tvalid && req_tready) board.take_pixel(req_tdata);
      end
   end

   // result side: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic csr_cycle(logic wr, logic [AW-1:0] addr, logic [DW-1:0] wdata,
                            output logic [DW-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write a register, then read it back
   task automatic write_reg(logic reg_sel, logic [DW-1:0] value);
      logic [AW-1:0] addr;
      logic [DW-1:0] readback;
      logic [DW-1:0] want;
      addr = {reg_sel, 2'b00};
      if (reg_sel == valp_pkg::REG_IMAGE_WIDTH)
         want = DW'(value[valp_pkg::CFG_WIDTH_W-1:0]);
      else
         want = DW'(value[valp_pkg::CFG_HEIGHT_W-1:0]);
      csr_cycle(1'b1, addr, value, readback);
      board.set_reg(addr, value);
      csr_cycle(1'b0, addr, '0, readback);
      if (readback !== want)
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   reg_sel, readback, want));
   endtask

   task automatic send_pixel(logic [7:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   // region-like labels: mostly copies of the left or upper pixel
   task automatic send_labels(int count);
      logic [7:0] pix;
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(99);
         if ($urandom_range(19) == 0)
            label_pool[$urandom_range(POOL_SIZE-1)] = 8'($urandom_range(255));
         if (roll < 10) pix = 8'($urandom_range(255));
         else if (roll < 45 && gen_col > 0) pix = gen_line[gen_col-1];
         else if (roll < 80) pix = gen_line[gen_col];
         else pix = label_pool[$urandom_range(POOL_SIZE-1)];
         gen_line[gen_col] = pix;
         gen_col = (gen_col + 1 >= gen_w) ? 0 : gen_col + 1;
         send_pixel(pix);
      end
   endtask

   // stop offering and let every pair due come out, plus the pipeline depth
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pairs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // finish the current row as the last one so the counters are back at the origin
   task automatic rewind_image();
      int unsigned w;
      int unsigned n;
      wait_idle();
      if (board.col_now != 0 || board.row_now != 0) begin
         write_reg(valp_pkg::REG_IMAGE_HEIGHT, 32'd1);
         w = board.eff_width();
         n = (board.col_now >= w) ? 1 : w - board.col_now;
         send_labels(n);
         wait_idle();
      end
   endtask

   // width is only raised at the origin so no unwritten store entry is read
   task automatic start_phase(logic [DW-1:0] width_val, logic [DW-1:0] height_val);
      rewind_image();
      write_reg(valp_pkg::REG_IMAGE_WIDTH, width_val);
      write_reg(valp_pkg::REG_IMAGE_HEIGHT, height_val);
      gen_w = board.eff_width();
      gen_col = 0;
      foreach (label_pool[i]) label_pool[i] = 8'($urandom_range(255));
   endtask

   task automatic set_idling(int send_pct, int stall);
      send_idle_pct = send_pct;
      stall_pct <= stall;
   endtask

   initial begin
      board = new();
      fail_count = 0;
      send_idle_pct = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      gen_col = 0;
      gen_w = 1;
      foreach (gen_line[i]) gen_line[i] = '0;
      foreach (label_pool[i]) label_pool[i] = '0;
      clock = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      stall_pct <= 0;
      hold_go <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corner image, then zero width and height
      write_reg(valp_pkg::REG_IMAGE_WIDTH, 32'd3);
      write_reg(valp_pkg::REG_IMAGE_HEIGHT, 32'd8);
      foreach (corner_labels[i]) send_pixel(corner_labels[i]);
      wait_idle();
      write_reg(valp_pkg::REG_IMAGE_WIDTH, 32'd0);
      write_reg(valp_pkg::REG_IMAGE_HEIGHT, 32'd0);
      send_pixel(8'd255);

      // width 3, tallest height, full rate
      start_phase(32'd3, 32'd4096);
      set_idling(0, 0);
      send_labels(PHASE_ITEMS);

      start_phase(32'($urandom_range(16, 4)), 32'($urandom_range(10, 3)));
      set_idling(54, 0);
      send_labels(PHASE_ITEMS);

      start_phase(32'($urandom_range(16, 4)), 32'($urandom_range(10, 3)));
      set_idling(0, 54);
      send_labels(PHASE_ITEMS);

      start_phase(32'($urandom_range(16, 4)), 32'($urandom_range(10, 3)));
      set_idling(28, 28);
      send_labels(PHASE_ITEMS);

      // long result hold-off while pixels keep coming
      start_phase(32'd6, 32'd9);
      set_idling(0, 0);
      hold_go <= 1'b1;
      send_labels(200);

      // no interior pixels
      start_phase(32'd2, 32'd5);
      set_idling(28, 28);
      send_labels(40);

      // widest raw width and tallest raw height, then narrowed mid-image
      start_phase(32'd2047, 32'd8191);
      set_idling(0, 28);
      send_labels(MAX_W + 40);
      wait_idle();
      write_reg(valp_pkg::REG_IMAGE_WIDTH, 32'd3);
      gen_w = 3;
      gen_col = 0;
      send_labels(30);

      start_phase(32'($urandom_range(40, 3)), 32'd3);
      set_idling(28, 28);
      send_labels(PHASE_ITEMS);

      start_phase(32'd1, 32'd2);
      set_idling(0, 0);
      send_labels(10);

      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
design/valp_pkg.sv
design/valp_line_buf.sv
design/valp_seen_filter.sv
design/valp_out_fifo.sv
design/voronoi_adjacent_label_pairs.sv
tb/tb_voronoi_adjacent_label_pairs.sv
